[rtl/core/vpm_pkg.sv]
// Shared constants and types for the view projection matrix pipeline.
`default_nettype none

package vpm_pkg;

  // Field widths of the divider lanes.
  localparam int unsigned DEN_W = 24;
  localparam int unsigned NUM_W = 58;
  localparam int unsigned DIV_LAT = NUM_W;
  localparam int unsigned LANES = 6;

  // Angle wrapping: 360 degrees in Q16.8, and an offset that makes any input positive.
  localparam logic [16:0] FULL_TURN = 17'd92160;
  localparam logic [16:0] HALF_TURN_STEP = 17'd46080;
  localparam logic [24:0] TURN_OFFSET = 25'd8478720;

  // Reciprocals of 45 for the two divisions by 92160 (45 times 2048).
  localparam logic [14:0] RECIP_45 = 15'd23302;
  localparam int unsigned RECIP_45_SHIFT = 20;
  localparam logic [22:0] RECIP_45_WIDE = 23'd5965233;
  localparam int unsigned RECIP_45_WIDE_SHIFT = 28;
  localparam int unsigned TURN_SHIFT = 11;

  // Q30 constants for the sine table.
  localparam logic [63:0] ONE_Q30 = 64'd1073741824;
  localparam logic [63:0] HALF_Q30 = 64'd536870912;
  localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
  localparam int unsigned SERIES_TERMS = 8;
  localparam logic [63:0] SERIES_DIV [SERIES_TERMS] = '{
    64'd272, 64'd210, 64'd156, 64'd110, 64'd72, 64'd42, 64'd20, 64'd6
  };

  // A size of 1.0 in Q16.8.
  localparam logic [23:0] SIZE_ONE = 24'd256;

  // Quadrant codes.
  localparam logic [1:0] QUAD_0 = 2'd0;
  localparam logic [1:0] QUAD_1 = 2'd1;
  localparam logic [1:0] QUAD_2 = 2'd2;
  localparam logic [1:0] QUAD_3 = 2'd3;

  // Per-transaction flags that travel alongside the divider lanes.
  typedef struct packed {
    logic             clamped;
    logic [LANES-1:0] neg;
  } side_t;

endpackage

`default_nettype wire

[rtl/core/vpm_divider.sv]
// Pipelined restoring divider, one quotient bit per register stage.
`default_nettype none

module vpm_divider (
  input  logic                       clk_i,
  input  logic [vpm_pkg::NUM_W-1:0]  num_i,
  input  logic [vpm_pkg::DEN_W-1:0]  den_i,
  output logic [vpm_pkg::NUM_W-1:0]  quo_o
);
  import vpm_pkg::*;

  logic [DEN_W-1:0] rem_q [NUM_W];
  logic [NUM_W-1:0] nq_q  [NUM_W];
  logic [DEN_W-1:0] den_q [NUM_W];

  // Each stage shifts in one numerator bit and makes one trial subtraction.
  for (genvar s = 0; s < NUM_W; s++) begin : g_stage
    logic [DEN_W-1:0] rem_in;
    logic [DEN_W-1:0] den_in;
    logic [NUM_W-1:0] nq_in;
    logic [DEN_W:0]   trial;
    logic             ge;

    if (s == 0) begin : g_first
      assign rem_in = '0;
      assign nq_in  = num_i;
      assign den_in = den_i;
    end else begin : g_next
      assign rem_in = rem_q[s-1];
      assign nq_in  = nq_q[s-1];
      assign den_in = den_q[s-1];
    end

    assign trial = {rem_in, nq_in[NUM_W-1]};
    assign ge    = (trial >= {1'b0, den_in});

    always_ff @(posedge clk_i) begin
      rem_q[s] <= ge ? DEN_W'(trial - {1'b0, den_in}) : trial[DEN_W-1:0];
      nq_q[s]  <= {nq_in[NUM_W-2:0], ge};
      den_q[s] <= den_in;
    end
  end

  assign quo_o = nq_q[NUM_W-1];

endmodule

`default_nettype wire

[rtl/core/view_projection_matrix.sv]
// View projection matrix of a 2D camera: deep pipeline from view to six matrix entries.
// Pipeline: 9 front stages for angle wrapping, table lookup and products, 58 divider
// stages and one output register before the done_o strobe.
// Throughput: one transaction per cycle; busy stays low and the receiver cannot stall.
// Reset clears only the valid bits; payload registers are not reset.
`default_nettype none

module view_projection_matrix #(
  parameter int unsigned SINE_TABLE_DEPTH = 1024
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start,
  output logic               busy,
  input  logic signed [23:0] center_x_i,
  input  logic signed [23:0] center_y_i,
  input  logic        [23:0] size_x_i,
  input  logic        [23:0] size_y_i,
  input  logic signed [23:0] angle_deg_i,
  output logic               done_o,
  output logic signed [31:0] m00_o,
  output logic signed [31:0] m01_o,
  output logic signed [63:0] m02_o,
  output logic signed [31:0] m10_o,
  output logic signed [31:0] m11_o,
  output logic signed [63:0] m12_o,
  output logic               size_clamped_o
);
  import vpm_pkg::*;

  localparam int unsigned TABLE_ENTRIES = SINE_TABLE_DEPTH + 1;
  localparam int unsigned IDX_W = $clog2(SINE_TABLE_DEPTH + 1);
  localparam int unsigned P_W = $clog2(4 * SINE_TABLE_DEPTH + 1);
  localparam longint unsigned Y_MAX =
    64'(FULL_TURN) * 64'(4 * SINE_TABLE_DEPTH) + 64'(HALF_TURN_STEP);
  localparam int unsigned Y_W = $clog2(Y_MAX + 1);
  localparam int unsigned PROD_W = Y_W - TURN_SHIFT + 23;
  localparam int unsigned SINE_W = 31;

  typedef struct packed {
    logic signed [23:0] cx;
    logic signed [23:0] cy;
    logic        [23:0] sx;
    logic        [23:0] sy;
    logic               clamped;
  } front_t;

  // Quarter-wave sine entry k in Q30, evaluated by a nested series.
  function automatic logic [63:0] quarter_sine(input logic [63:0] k);
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] t;
    logic [63:0] s;
    x  = (k * HALF_PI_Q30 + 64'(SINE_TABLE_DEPTH / 2)) / 64'(SINE_TABLE_DEPTH);
    x2 = (x * x + HALF_Q30) >> 30;
    t  = ONE_Q30;
    for (int j = 0; j < SERIES_TERMS; j++) begin
      t = ONE_Q30 - (((x2 * t + HALF_Q30) >> 30) / SERIES_DIV[j]);
    end
    s = (x * t + HALF_Q30) >> 30;
    if (s > ONE_Q30) begin
      s = ONE_Q30;
    end
    return s;
  endfunction

  // Signed Q2.30 result from a quotient magnitude, saturating on the positive side only.
  function automatic logic [31:0] sat_q30(input logic [NUM_W-1:0] q, input logic neg);
    logic [31:0] v;
    if (neg) begin
      v = 32'(0) - q[31:0];
    end else if (q > NUM_W'(32'h7FFF_FFFF)) begin
      v = 32'h7FFF_FFFF;
    end else begin
      v = q[31:0];
    end
    return v;
  endfunction

  // Quarter-wave sine ROM.
  logic [SINE_W-1:0] sine_rom [TABLE_ENTRIES];
  for (genvar k = 0; k < TABLE_ENTRIES; k++) begin : g_rom
    assign sine_rom[k] = SINE_W'(quarter_sine(64'(k)));
  end

  assign busy = 1'b0;

  // Stage 1: clamp the sizes and offset the angle to a positive value.
  logic        v1_q;
  front_t      f1_q;
  logic [24:0] ap1_q;
  front_t      f1_d;
  logic [24:0] ap1_d;

  always_comb begin
    f1_d.cx      = center_x_i;
    f1_d.cy      = center_y_i;
    f1_d.sx      = (size_x_i < SIZE_ONE) ? SIZE_ONE : size_x_i;
    f1_d.sy      = (size_y_i < SIZE_ONE) ? SIZE_ONE : size_y_i;
    f1_d.clamped = (size_x_i < SIZE_ONE) || (size_y_i < SIZE_ONE);
    ap1_d        = {angle_deg_i[23], angle_deg_i} + TURN_OFFSET;
  end

  // Stage 2: whole turns in the offset angle.
  logic        v2_q;
  front_t      f2_q;
  logic [24:0] ap2_q;
  logic [8:0]  qt2_q;
  logic [28:0] qprod;

  assign qprod = 29'(ap1_q[24:TURN_SHIFT]) * 29'(RECIP_45);

  // Stage 3: remainder in the turn, scaled to table phase steps.
  logic           v3_q;
  front_t         f3_q;
  logic [Y_W-1:0] y3_q;
  logic [24:0]    rsub;
  logic [Y_W-1:0] y3_d;

  always_comb begin
    rsub = ap2_q - 25'(25'(qt2_q) * 25'(FULL_TURN));
    y3_d = Y_W'(rsub[16:0]) * Y_W'(4 * SINE_TABLE_DEPTH) + Y_W'(HALF_TURN_STEP);
  end

  // Stage 4: rounded phase through a reciprocal of the turn length.
  logic              v4_q;
  front_t            f4_q;
  logic [PROD_W-1:0] pr4_q;

  // Stage 5: quadrant and table indexes.
  logic             v5_q;
  front_t           f5_q;
  logic [1:0]       quad5_q;
  logic [IDX_W-1:0] i5_q;
  logic [IDX_W-1:0] ic5_q;
  logic [P_W-1:0]   phase;
  logic [1:0]       quad5_d;
  logic [IDX_W-1:0] i5_d;

  always_comb begin
    phase = P_W'(pr4_q >> RECIP_45_WIDE_SHIFT);
    if (phase >= P_W'(4 * SINE_TABLE_DEPTH)) begin
      phase = '0;
    end
    if (phase >= P_W'(3 * SINE_TABLE_DEPTH)) begin
      quad5_d = QUAD_3;
      i5_d    = IDX_W'(phase - P_W'(3 * SINE_TABLE_DEPTH));
    end else if (phase >= P_W'(2 * SINE_TABLE_DEPTH)) begin
      quad5_d = QUAD_2;
      i5_d    = IDX_W'(phase - P_W'(2 * SINE_TABLE_DEPTH));
    end else if (phase >= P_W'(SINE_TABLE_DEPTH)) begin
      quad5_d = QUAD_1;
      i5_d    = IDX_W'(phase - P_W'(SINE_TABLE_DEPTH));
    end else begin
      quad5_d = QUAD_0;
      i5_d    = IDX_W'(phase);
    end
  end

  // Stage 6: registered table reads.
  logic              v6_q;
  front_t            f6_q;
  logic [1:0]        quad6_q;
  logic [SINE_W-1:0] ti6_q;
  logic [SINE_W-1:0] tc6_q;

  // Stage 7: sine and cosine by quadrant.
  logic               v7_q;
  front_t             f7_q;
  logic signed [31:0] sn7_q;
  logic signed [31:0] cs7_q;
  logic signed [31:0] sn7_d;
  logic signed [31:0] cs7_d;
  logic signed [31:0] ti_s;
  logic signed [31:0] tc_s;

  always_comb begin
    ti_s = $signed({1'b0, ti6_q});
    tc_s = $signed({1'b0, tc6_q});
    case (quad6_q)
      QUAD_0: begin
        sn7_d = ti_s;
        cs7_d = tc_s;
      end
      QUAD_1: begin
        sn7_d = tc_s;
        cs7_d = -ti_s;
      end
      QUAD_2: begin
        sn7_d = -ti_s;
        cs7_d = -tc_s;
      end
      default: begin
        sn7_d = -tc_s;
        cs7_d = ti_s;
      end
    endcase
  end

  // Stage 8: centre products for the translation terms.
  logic               v8_q;
  front_t             f8_q;
  logic signed [31:0] sn8_q;
  logic signed [31:0] cs8_q;
  logic signed [55:0] cxcs8_q;
  logic signed [55:0] cysn8_q;
  logic signed [55:0] cxsn8_q;
  logic signed [55:0] cycs8_q;

  // Stage 9: signed numerators, then rounded magnitudes for the dividers.
  logic               v9_q;
  logic [DEN_W-1:0]   sx9_q;
  logic [DEN_W-1:0]   sy9_q;
  side_t              side9_q;
  logic [NUM_W-1:0]   mag9_q [LANES];
  logic signed [59:0] numer [LANES];
  logic [59:0]        absn  [LANES];
  logic [NUM_W-1:0]   mag9_d [LANES];
  side_t              side9_d;

  always_comb begin
    numer[0] = 60'(cs8_q) <<< 9;
    numer[1] = 60'(sn8_q) <<< 9;
    numer[2] = (60'(0) - 60'(cxcs8_q) - 60'(cysn8_q)) <<< 3;
    numer[3] = 60'(sn8_q) <<< 9;
    numer[4] = (60'(0) - 60'(cs8_q)) <<< 9;
    numer[5] = (60'(cycs8_q) - 60'(cxsn8_q)) <<< 3;
    side9_d.clamped = f8_q.clamped;
    for (int k = 0; k < LANES; k++) begin
      side9_d.neg[k] = numer[k][59];
      absn[k] = numer[k][59] ? 60'(0) - 60'(numer[k]) : 60'(numer[k]);
      if (k < 3) begin
        mag9_d[k] = NUM_W'(absn[k]) + NUM_W'(f8_q.sx >> 1);
      end else begin
        mag9_d[k] = NUM_W'(absn[k]) + NUM_W'(f8_q.sy >> 1);
      end
    end
  end

  // Valid bits of the front stages.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
      v5_q <= 1'b0;
      v6_q <= 1'b0;
      v7_q <= 1'b0;
      v8_q <= 1'b0;
      v9_q <= 1'b0;
    end else begin
      v1_q <= start && !busy;
      v2_q <= v1_q;
      v3_q <= v2_q;
      v4_q <= v3_q;
      v5_q <= v4_q;
      v6_q <= v5_q;
      v7_q <= v6_q;
      v8_q <= v7_q;
      v9_q <= v8_q;
    end
  end

  // Payload of the front stages.
  always_ff @(posedge clk_i) begin
    f1_q    <= f1_d;
    ap1_q   <= ap1_d;
    f2_q    <= f1_q;
    ap2_q   <= ap1_q;
    qt2_q   <= qprod[28:RECIP_45_SHIFT];
    f3_q    <= f2_q;
    y3_q    <= y3_d;
    f4_q    <= f3_q;
    pr4_q   <= PROD_W'(y3_q[Y_W-1:TURN_SHIFT]) * PROD_W'(RECIP_45_WIDE);
    f5_q    <= f4_q;
    quad5_q <= quad5_d;
    i5_q    <= i5_d;
    ic5_q   <= IDX_W'(SINE_TABLE_DEPTH) - i5_d;
    f6_q    <= f5_q;
    quad6_q <= quad5_q;
    ti6_q   <= sine_rom[i5_q];
    tc6_q   <= sine_rom[ic5_q];
    f7_q    <= f6_q;
    sn7_q   <= sn7_d;
    cs7_q   <= cs7_d;
    f8_q    <= f7_q;
    sn8_q   <= sn7_q;
    cs8_q   <= cs7_q;
    cxcs8_q <= 56'(f7_q.cx) * 56'(cs7_q);
    cysn8_q <= 56'(f7_q.cy) * 56'(sn7_q);
    cxsn8_q <= 56'(f7_q.cx) * 56'(sn7_q);
    cycs8_q <= 56'(f7_q.cy) * 56'(cs7_q);
    sx9_q   <= f8_q.sx;
    sy9_q   <= f8_q.sy;
    side9_q <= side9_d;
    for (int k = 0; k < LANES; k++) begin
      mag9_q[k] <= mag9_d[k];
    end
  end

  // Six divider lanes: the first three divide by the width, the rest by the height.
  logic [NUM_W-1:0] quo [LANES];
  for (genvar k = 0; k < LANES; k++) begin : g_lane
    vpm_divider u_div (
      .clk_i (clk_i),
      .num_i (mag9_q[k]),
      .den_i ((k < 3) ? sx9_q : sy9_q),
      .quo_o (quo[k])
    );
  end

  // Valid bits and flags that keep step with the dividers.
  logic  vd_q [DIV_LAT];
  side_t sd_q [DIV_LAT];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int s = 0; s < DIV_LAT; s++) begin
        vd_q[s] <= 1'b0;
      end
    end else begin
      vd_q[0] <= v9_q;
      for (int s = 1; s < DIV_LAT; s++) begin
        vd_q[s] <= vd_q[s-1];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    sd_q[0] <= side9_q;
    for (int s = 1; s < DIV_LAT; s++) begin
      sd_q[s] <= sd_q[s-1];
    end
  end

  // Output register: signs, saturation and the strobe for one cycle.
  side_t last_side;
  assign last_side = sd_q[DIV_LAT-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_o <= 1'b0;
    end else begin
      done_o <= vd_q[DIV_LAT-1];
    end
  end

  always_ff @(posedge clk_i) begin
    m00_o <= sat_q30(quo[0], last_side.neg[0]);
    m01_o <= sat_q30(quo[1], last_side.neg[1]);
    m02_o <= last_side.neg[2] ? 64'(0) - 64'(quo[2]) : 64'(quo[2]);
    m10_o <= sat_q30(quo[3], last_side.neg[3]);
    m11_o <= sat_q30(quo[4], last_side.neg[4]);
    m12_o <= last_side.neg[5] ? 64'(0) - 64'(quo[5]) : 64'(quo[5]);
    size_clamped_o <= last_side.clamped;
  end

endmodule

`default_nettype wire
